// File: src/tlru_pkg.sv
// ----------------------------------------------------------------------------
// tlru_pkg
// Shared types, widths and helpers for the true LRU replacement block.
// ----------------------------------------------------------------------------
package tlru_pkg;

    localparam int SETS_DEF = 1024;
    localparam int WAYS_DEF = 16;
    localparam int MAX_WAYS = 16;
    localparam int POS_W    = 4;
    localparam int SET_W    = 10;
    localparam int WAY_W    = 4;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 8;
    localparam int SETX_W   = 17;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
    } tlru_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } tlru_sts_t;

    // way i at position i
    function automatic logic [MAX_WAYS*POS_W-1:0] init_word(input int ways);
        logic [MAX_WAYS*POS_W-1:0] word;
        word = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (w < ways)
            begin
                word[w*POS_W +: POS_W] = POS_W'(w);
            end
        end
        return word;
    endfunction

endpackage

// File: src/tlru_ram.sv
// ----------------------------------------------------------------------------
// tlru_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlru_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/tlru_ctrl.sv
// ----------------------------------------------------------------------------
// tlru_ctrl
// Sequencer: clearing pass after reset, then accept, read-modify-write, commit.
// ----------------------------------------------------------------------------
module tlru_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tlru_pkg::tlru_sts_t sts,
    output tlru_pkg::tlru_cmd_t cmd
);
    import tlru_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WORK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        cmd.clear   = (state_reg == ST_CLEAR);
        cmd.capture = s_tvalid && ready_reg;
        cmd.commit  = (state_reg == ST_WORK) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

// File: src/tlru_dp.sv
// ----------------------------------------------------------------------------
// tlru_dp
// Datapath: set memory, clear counter, recency update, victim search, output.
// ----------------------------------------------------------------------------
module tlru_dp #(
    parameter int SETS = tlru_pkg::SETS_DEF,
    parameter int WAYS = tlru_pkg::WAYS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tlru_pkg::tlru_cmd_t        cmd,
    output tlru_pkg::tlru_sts_t        sts,
    input  logic                       in_action,
    input  logic [tlru_pkg::SET_W-1:0] in_set_index,
    input  logic [tlru_pkg::WAY_W-1:0] in_way,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [tlru_pkg::WAY_W-1:0] out_victim_way,
    output logic                       out_victim_valid
);
    import tlru_pkg::*;

    localparam int AW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WORD_W = WAYS * POS_W;
    localparam int WIDX_W = $clog2(WAYS);
    localparam logic [MAX_WAYS*POS_W-1:0] INIT_FULL = init_word(WAYS);

    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     clr_cnt_next;
    logic              act_reg;
    logic              set_ok_reg;
    logic              way_ok_reg;
    logic [AW-1:0]     addr_reg;
    logic [WIDX_W-1:0] widx_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WAY_W-1:0]  out_way_reg;
    logic              out_flag_reg;

    logic [SETX_W-1:0] set_ext;
    logic [AW-1:0]     in_addr;
    logic              in_set_ok;
    logic              in_way_ok;

    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] new_word;
    logic [WORD_W-1:0] wdata;
    logic [AW-1:0]     waddr;
    logic              we;
    logic [POS_W-1:0]  pos [WAYS];
    logic [POS_W-1:0]  old_pos;
    logic [WAY_W-1:0]  victim;

    assign set_ext   = SETX_W'(in_set_index);
    assign in_addr   = set_ext[AW-1:0];
    assign in_set_ok = set_ext < SETX_W'(SETS);
    assign in_way_ok = {1'b0, in_way} < (WAY_W + 1)'(WAYS);

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            pos[w] = rdata[w*POS_W +: POS_W];
        end
        old_pos = pos[widx_reg];
    end

    always_comb
    begin
        new_word = rdata;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WIDX_W'(w) == widx_reg)
            begin
                new_word[w*POS_W +: POS_W] = '0;
            end
            else if (pos[w] < old_pos)
            begin
                new_word[w*POS_W +: POS_W] = pos[w] + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (pos[w] == POS_W'(WAYS - 1))
            begin
                victim = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        we    = cmd.clear
              || (cmd.commit && (act_reg == ACT_UPDATE) && set_ok_reg && way_ok_reg);
        waddr = cmd.clear ? clr_cnt_reg : addr_reg;
        wdata = cmd.clear ? INIT_FULL[WORD_W-1:0] : new_word;
    end

    tlru_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SETS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.capture),
        .raddr (in_addr),
        .rdata (rdata)
    );

    assign clr_cnt_next   = cmd.clear ? AW'(clr_cnt_reg + AW'(1)) : clr_cnt_reg;
    assign out_valid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg    <= in_action;
            set_ok_reg <= in_set_ok;
            way_ok_reg <= in_way_ok;
            addr_reg   <= in_addr;
            widx_reg   <= in_way[WIDX_W-1:0];
        end
        if (cmd.commit)
        begin
            out_flag_reg <= act_reg;
            out_way_reg  <= ((act_reg == ACT_QUERY) && set_ok_reg) ? victim : '0;
        end
    end

    assign sts.clear_last   = cmd.clear && (clr_cnt_reg == AW'(SETS - 1));
    assign sts.out_free     = !out_valid_reg || m_tready;
    assign m_tvalid         = out_valid_reg;
    assign out_victim_way   = out_way_reg;
    assign out_victim_valid = out_flag_reg;

endmodule

// File: src/true_lru_replacement_core.sv
// An accepted input beat is registered with the set memory read; its result beat is
// registered at the commit, which waits for a free output. No new beat is taken until
// that commit. Reset: asynchronous, active low; afterwards a clearing pass writes the
// initial order into every one of the SETS sets (1024 by default), s_tready held low.
// ----------------------------------------------------------------------------
// true_lru_replacement_core
// Per-set true LRU recency stacks with update and victim query.
// ----------------------------------------------------------------------------
module true_lru_replacement_core #(
    parameter int SETS = tlru_pkg::SETS_DEF,
    parameter int WAYS = tlru_pkg::WAYS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tlru_pkg::IN_W-1:0]  s_tdata,   // action, set_index, way
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [tlru_pkg::OUT_W-1:0] m_tdata,   // victim_way
    output logic                       m_tuser    // victim_valid
);
    import tlru_pkg::*;

    tlru_cmd_t        cmd;
    tlru_sts_t        sts;
    logic [WAY_W-1:0] victim_way;

    tlru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlru_dp #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_action        (s_tdata[0]),
        .in_set_index     (s_tdata[SET_W:1]),
        .in_way           (s_tdata[SET_W+WAY_W:SET_W+1]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .out_victim_way   (victim_way),
        .out_victim_valid (m_tuser)
    );

    assign m_tdata = {(OUT_W - WAY_W)'(0), victim_way};

endmodule

// File: src/tlru_checker.sv
// ----------------------------------------------------------------------------
// tlru_checker
// Port-level checks for the true LRU replacement core.
// ----------------------------------------------------------------------------
module tlru_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [tlru_pkg::IN_W-1:0]  s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [tlru_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken during read-modify-write");

    a_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("update result carries a victim way");

    logic unused_s_tdata;
    assign unused_s_tdata = ^s_tdata;

endmodule

bind true_lru_replacement_core tlru_checker u_tlru_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
